// File: rtl/eist_pkg.sv
// ----------------------------------------------------------------------------
// eist_pkg
// shared types and codes for the enrolled id slot table
// ----------------------------------------------------------------------------
package eist_pkg;

   localparam logic [3:0] ACT_ENROLL     = 4'd0;
   localparam logic [3:0] ACT_DELETE     = 4'd1;
   localparam logic [3:0] ACT_DELETE_ID  = 4'd2;
   localparam logic [3:0] ACT_DELETE_ALL = 4'd3;
   localparam logic [3:0] ACT_CHECK      = 4'd4;
   localparam logic [3:0] ACT_CHECK_MGR  = 4'd5;
   localparam logic [3:0] ACT_MGR_FINGER = 4'd6;
   localparam logic [3:0] ACT_COUNT      = 4'd7;
   localparam logic [3:0] ACT_NEXT       = 4'd8;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam int FINGERS = 256;

   typedef struct packed {
      logic [3:0]  action;
      logic [31:0] user_id;
      logic [7:0]  finger_number;
      logic [7:0]  manager_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] slot_index;
      logic [12:0] result_value;
   } rsp_type;

   // command word that travels down the cell chain together with the sweep
   typedef struct packed {
      logic        active;
      logic [3:0]  action;
      logic [31:0] user_id;
      logic [7:0]  finger;
      logic        manager;
      logic        wr_en;      // write back phase of enroll
      logic [11:0] wr_slot;
   } cmd_type;

   // partial results gathered along the chain
   typedef struct packed {
      logic        hit_found;
      logic [11:0] hit_slot;
      logic        hit_mgr;
      logic        free_found;
      logic [11:0] free_slot;
      logic        mgr_found;
      logic [7:0]  mgr_finger;
      logic        id_found;
      logic [7:0]  low_finger;
      logic [12:0] count;
   } acc_type;

endpackage

// File: rtl/eist_if.sv
// ----------------------------------------------------------------------------
// eist_req_if / eist_rsp_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface eist_req_if;
   import eist_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface eist_rsp_if;
   import eist_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/eist_cell.sv
// ----------------------------------------------------------------------------
// eist_cell
// one slot of the table: holds its entry, compares it against the command
// and passes command and running results to the next cell
// ----------------------------------------------------------------------------
module eist_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  eist_pkg::cmd_type cmd_i,
   input  eist_pkg::acc_type acc_i,
   output eist_pkg::cmd_type cmd_o,
   output eist_pkg::acc_type acc_o,
   output logic [eist_pkg::FINGERS-1:0] mark_o
);
   import eist_pkg::*;

   localparam logic [11:0] MY_SLOT = 12'(INDEX);

   logic        valid_ff, valid_in;
   logic [31:0] id_ff;
   logic [7:0]  finger_ff;
   logic        mgr_ff;
   cmd_type     cmd_ff;
   acc_type     acc_ff, acc_in;
   logic        id_hit, entry_hit, wr_here;

   assign id_hit    = valid_ff && (id_ff == cmd_i.user_id);
   assign entry_hit = id_hit && (finger_ff == cmd_i.finger);
   assign wr_here   = cmd_i.active && cmd_i.wr_en && (cmd_i.wr_slot == MY_SLOT);

   always_comb begin
      valid_in = valid_ff;
      acc_in   = acc_i;
      if (cmd_i.active && !cmd_i.wr_en) begin
         if (entry_hit && !acc_i.hit_found) begin
            acc_in.hit_found = 1'b1;
            acc_in.hit_slot  = MY_SLOT;
            acc_in.hit_mgr   = mgr_ff;
         end
         if (!valid_ff && !acc_i.free_found) begin
            acc_in.free_found = 1'b1;
            acc_in.free_slot  = MY_SLOT;
         end
         if (id_hit && mgr_ff && !acc_i.mgr_found) begin
            acc_in.mgr_found  = 1'b1;
            acc_in.mgr_finger = finger_ff;
         end
         if (id_hit) begin
            acc_in.id_found = 1'b1;
            if (!acc_i.id_found || finger_ff < acc_i.low_finger)
               acc_in.low_finger = finger_ff;
         end
         if (valid_ff) acc_in.count = acc_i.count + 13'd1;
         unique case (cmd_i.action)
            ACT_DELETE:     if (entry_hit && !acc_i.hit_found) valid_in = 1'b0;
            ACT_DELETE_ID:  if (id_hit) valid_in = 1'b0;
            ACT_DELETE_ALL: valid_in = 1'b0;
            default:        ;
         endcase
      end
      if (wr_here) valid_in = 1'b1;
   end

   always_comb begin
      mark_o = '0;
      if (valid_ff && id_ff == cmd_ff.user_id && cmd_ff.active && !cmd_ff.wr_en)
         mark_o[finger_ff] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         cmd_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         cmd_ff   <= cmd_i;
      end
      acc_ff <= acc_in;
      if (wr_here) begin
         id_ff     <= cmd_i.user_id;
         finger_ff <= cmd_i.finger;
         mgr_ff    <= cmd_i.manager;
      end
   end

   assign cmd_o = cmd_ff;
   assign acc_o = acc_ff;
endmodule

// File: rtl/eist_ctrl.sv
// ----------------------------------------------------------------------------
// eist_ctrl
// sequencer: launches the sweep, collects the chain result, runs the
// enroll write pass and the next finger search, holds the response
// ----------------------------------------------------------------------------
module eist_ctrl (
   input  logic              clock,
   input  logic              reset,
   eist_req_if.sink          req,
   eist_rsp_if.source        rsp,
   output eist_pkg::cmd_type cmd_o,
   input  eist_pkg::cmd_type cmd_i,
   input  eist_pkg::acc_type acc_i,
   input  logic [eist_pkg::FINGERS-1:0] marks_i
);
   import eist_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SWEEP = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_NEXT  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]   state_ff, state_in;
   req_type      req_ff, req_in;
   logic [FINGERS-1:0] bits_ff, bits_in;
   logic [8:0]   scan_ff, scan_in;
   rsp_type      rsp_ff, rsp_in;
   logic [11:0]  wslot_ff, wslot_in;
   logic         launch, write_go;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.data  = rsp_ff;

   always_comb begin
      cmd_o         = '0;
      cmd_o.action  = req_ff.action;
      cmd_o.user_id = req_ff.user_id;
      cmd_o.finger  = req_ff.finger_number;
      cmd_o.manager = (req_ff.manager_level != 8'd0);
      cmd_o.active  = launch || write_go;
      cmd_o.wr_en   = write_go;
      cmd_o.wr_slot = wslot_ff;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      bits_in  = bits_ff;
      scan_in  = scan_ff;
      rsp_in   = rsp_ff;
      wslot_in = wslot_ff;
      launch   = 1'b0;
      write_go = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req.valid) begin
            req_in   = req.data;
            bits_in  = '0;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            // fire once when the command enters, then wait for it at the end
            if (scan_ff == 9'd0) begin
               launch  = 1'b1;
               scan_in = 9'd1;
            end
            bits_in = bits_ff | marks_i;
            if (cmd_i.active && !cmd_i.wr_en) begin
               rsp_in  = '0;
               scan_in = 9'd0;
               state_in = S_RESP;
               unique case (req_ff.action)
                  ACT_ENROLL:
                     if (acc_i.hit_found || acc_i.free_found) begin
                        wslot_in = acc_i.hit_found ? acc_i.hit_slot : acc_i.free_slot;
                        rsp_in.slot_index = wslot_in;
                        state_in = S_WRITE;
                     end else rsp_in.status = ST_FULL;
                  ACT_DELETE, ACT_CHECK:
                     if (!acc_i.hit_found) rsp_in.status = ST_NOT_FOUND;
                  ACT_DELETE_ID:
                     if (!acc_i.id_found) rsp_in.status = ST_NOT_FOUND;
                  ACT_CHECK_MGR:
                     if (!(acc_i.hit_found && acc_i.hit_mgr)) rsp_in.status = ST_NOT_FOUND;
                  ACT_MGR_FINGER:
                     if (acc_i.mgr_found) rsp_in.result_value = {5'd0, acc_i.mgr_finger};
                     else rsp_in.status = ST_NOT_FOUND;
                  ACT_COUNT: rsp_in.result_value = acc_i.count;
                  ACT_NEXT:
                     if (acc_i.id_found) begin
                        scan_in  = {1'b0, acc_i.low_finger} + 9'd1;
                        state_in = S_NEXT;
                     end else rsp_in.status = ST_NOT_FOUND;
                  default: ;
               endcase
            end
         end
         S_WRITE: begin
            // write pass travels the chain; the target cell catches it
            if (scan_ff == 9'd0) begin
               write_go = 1'b1;
               scan_in  = 9'd1;
            end
            if (cmd_i.active && cmd_i.wr_en) begin
               scan_in  = 9'd0;
               state_in = S_RESP;
            end
         end
         S_NEXT: begin
            if (scan_ff[8] || !bits_ff[scan_ff[7:0]]) begin
               rsp_in.result_value = {4'd0, scan_ff};
               scan_in  = 9'd0;
               state_in = S_RESP;
            end else scan_in = scan_ff + 9'd1;
         end
         S_RESP: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= 9'd0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
      req_ff   <= req_in;
      bits_ff  <= bits_in;
      rsp_ff   <= rsp_in;
      wslot_ff <= wslot_in;
   end
endmodule

// File: rtl/enrolled_id_slot_table_top.sv
// ----------------------------------------------------------------------------
// enrolled_id_slot_table_top
// table of enrollment slots built as a chain of slot cells
// ----------------------------------------------------------------------------
// req channel: one action with id, finger and manager level; transfer when
// valid and ready are high. rsp channel: status, slot index, result value.
// one request at a time: req ready is high only while the block is idle.
// the command walks the chain one cell per cycle, then the response is
// offered. enroll adds a second pass down the chain to write the chosen
// slot. next finger then steps upward from the lowest finger plus one past
// each consecutive enrolled finger, up to 256. a new request is taken only
// after the response to the last one has been taken.
// the response stays on rsp until it is taken; a stalled receiver holds
// the block. reset clears every valid flag at once, so no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module enrolled_id_slot_table_top #(
   parameter int unsigned SLOTS = 256
) (
   input logic        clock,
   input logic        reset,
   eist_req_if.sink   req,
   eist_rsp_if.source rsp
);
   import eist_pkg::*;

   cmd_type cmd [SLOTS+1];
   acc_type acc [SLOTS+1];
   logic [FINGERS-1:0] mark [SLOTS];
   logic [FINGERS-1:0] marks;

   assign acc[0] = '0;

   always_comb begin
      marks = '0;
      for (int i = 0; i < int'(SLOTS); i++) marks = marks | mark[i];
   end

   eist_ctrl u_ctrl (
      .clock, .reset, .req, .rsp,
      .cmd_o(cmd[0]), .cmd_i(cmd[SLOTS]), .acc_i(acc[SLOTS]), .marks_i(marks)
   );

   for (genvar g = 0; g < int'(SLOTS); g++) begin : g_cell
      eist_cell #(.INDEX(g)) u_cell (
         .clock, .reset,
         .cmd_i(cmd[g]), .acc_i(acc[g]),
         .cmd_o(cmd[g+1]), .acc_o(acc[g+1]), .mark_o(mark[g])
      );
   end
endmodule

// File: rtl/eist_checker.sv
// ----------------------------------------------------------------------------
// eist_checker
// port level checks on the slot table
// ----------------------------------------------------------------------------
module eist_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input eist_pkg::rsp_type rsp_data
);
   import eist_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("accepting while response pending");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("bad status");
endmodule

bind enrolled_id_slot_table_top eist_checker u_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// File: test/tb_enrolled_id_slot_table_top.sv
// ----------------------------------------------------------------------------
// tb_enrolled_id_slot_table_top
// self-checking bench for the enrolled id slot table. a directed table of
// actions runs first, then random traffic over a small pool of ids and
// fingers, a fill to table full and full-range noise. every response is
// compared with a behavioral copy of the slot table kept in the bench, or with its row's typed expectation.
// ----------------------------------------------------------------------------
module tb_enrolled_id_slot_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import eist_pkg::*;

   localparam int NSLOT = 256;
   localparam logic [3:0] ACT_UNKNOWN_LO = 4'd9;
   localparam logic [3:0] ACT_UNKNOWN_HI = 4'd15;

   logic clock;
   logic reset;

   eist_req_if req_if ();
   eist_rsp_if rsp_if ();

   enrolled_id_slot_table_top #(.SLOTS(NSLOT)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // bench copy of the table
   bit          tbl_valid [NSLOT];
   logic [31:0] tbl_id    [NSLOT];
   logic [7:0]  tbl_finger[NSLOT];
   bit          tbl_mgr   [NSLOT];

   rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      cycle_cnt  = 0;

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } dir_row_t;
   dir_row_t dir_rows[$];

   logic [31:0] id_pool[8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("FAIL enrolled_id_slot_table_top");
      $finish;
   end

   function automatic int find_entry(logic [31:0] id, logic [7:0] f);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_id[i] == id && tbl_finger[i] == f) return i;
      return NSLOT;
   endfunction

   function automatic int find_free();
      for (int i = 0; i < NSLOT; i++)
         if (!tbl_valid[i]) return i;
      return NSLOT;
   endfunction

   // applies one action to the bench table and returns its response
   function automatic rsp_type apply_action(req_type r);
      rsp_type o;
      int pos;
      int n;
      int low;
      int v;
      bit [255:0] present;
      o = '0;
      case (r.action)
         ACT_ENROLL: begin
            pos = find_entry(r.user_id, r.finger_number);
            if (pos >= NSLOT) pos = find_free();
            if (pos >= NSLOT) o.status = ST_FULL;
            else begin
               tbl_valid[pos]  = 1'b1;
               tbl_id[pos]     = r.user_id;
               tbl_finger[pos] = r.finger_number;
               tbl_mgr[pos]    = (r.manager_level != 8'd0);
               o.slot_index    = 12'(pos);
            end
         end
         ACT_DELETE: begin
            pos = find_entry(r.user_id, r.finger_number);
            if (pos >= NSLOT) o.status = ST_NOT_FOUND;
            else tbl_valid[pos] = 1'b0;
         end
         ACT_DELETE_ID: begin
            n = 0;
            for (int i = 0; i < NSLOT; i++)
               if (tbl_valid[i] && tbl_id[i] == r.user_id) begin
                  tbl_valid[i] = 1'b0;
                  n++;
               end
            if (n == 0) o.status = ST_NOT_FOUND;
         end
         ACT_DELETE_ALL: begin
            for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
         end
         ACT_CHECK: begin
            if (find_entry(r.user_id, r.finger_number) >= NSLOT) o.status = ST_NOT_FOUND;
         end
         ACT_CHECK_MGR: begin
            pos = find_entry(r.user_id, r.finger_number);
            if (pos >= NSLOT || !tbl_mgr[pos]) o.status = ST_NOT_FOUND;
         end
         ACT_MGR_FINGER: begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < NSLOT; i++)
               if (tbl_valid[i] && tbl_id[i] == r.user_id && tbl_mgr[i]) begin
                  o.result_value = 13'(tbl_finger[i]);
                  o.status = ST_OK;
                  break;
               end
         end
         ACT_COUNT: begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) n++;
            o.result_value = 13'(n);
         end
         ACT_NEXT: begin
            present = '0;
            low = 256;
            for (int i = 0; i < NSLOT; i++)
               if (tbl_valid[i] && tbl_id[i] == r.user_id) begin
                  present[tbl_finger[i]] = 1'b1;
                  if (tbl_finger[i] < low) low = tbl_finger[i];
               end
            if (low > 255) o.status = ST_NOT_FOUND;
            else begin
               v = low + 1;
               while (v <= 255 && present[v]) v++;
               o.result_value = 13'(v);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // offer one request, wait for the transfer, then record its response
   task automatic send(req_type r, bit typed = 0, rsp_type e = '0);
      rsp_type p;
      int g;
      req_if.data  <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      p = apply_action(r);
      pending_rsp.push_back(typed ? e : p);
      g = pick_gap();
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   function automatic void add_row(logic [3:0] a, logic [31:0] id, logic [7:0] f,
                                   logic [7:0] m, bit typed = 0, logic [1:0] st = ST_OK,
                                   logic [11:0] sl = '0, logic [12:0] v = '0);
      dir_row_t d;
      d.r = '{action: a, user_id: id, finger_number: f, manager_level: m};
      d.typed = typed;
      d.e = '{status: st, slot_index: sl, result_value: v};
      dir_rows.push_back(d);
   endfunction

   function automatic req_type pool_req(bit wide_noise);
      req_type r;
      int p;
      p = $urandom_range(0, 99);
      if (p < 35) r.action = ACT_ENROLL;
      else if (p < 92) r.action = 4'($urandom_range(1, 8));
      else if (p < 94) r.action = ACT_DELETE_ALL;
      else r.action = 4'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
      if (wide_noise && $urandom_range(0, 3) == 0) r.user_id = $urandom;
      else r.user_id = id_pool[$urandom_range(0, 7)];
      p = $urandom_range(0, 9);
      if (p < 6) r.finger_number = 8'($urandom_range(0, 7));
      else if (p < 8) r.finger_number = 8'($urandom_range(248, 255));
      else r.finger_number = 8'($urandom);
      r.manager_level = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
      return r;
   endfunction

   // response side: random back-pressure plus one long hold-off
   initial begin
      int hold;
      hold = 0;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt == 20000) hold = 5000;
         if (hold > 0) begin
            hold--;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            hold = pick_gap();
            rsp_if.ready <= (hold == 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_if.data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.data.status !== want.status
                || rsp_if.data.slot_index !== want.slot_index
                || rsp_if.data.result_value !== want.result_value) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st=%0d slot=%0d val=%0d, got st=%0d slot=%0d val=%0d",
                           want.status, want.slot_index, want.result_value,
                           rsp_if.data.status, rsp_if.data.slot_index,
                           rsp_if.data.result_value);
            end
         end
      end
   end

   initial begin
      req_type r;
      int wait_cnt;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_id[i] = '0;
         tbl_finger[i] = '0;
         tbl_mgr[i] = 1'b0;
      end
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFF;
      id_pool[2] = 32'h8000_0000;
      for (int i = 3; i < 8; i++) id_pool[i] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, missing entries, unknown actions
      add_row(ACT_COUNT,      32'd5, 8'd0, 8'd0, 1, ST_OK,        0, 0);
      add_row(ACT_NEXT,       32'd5, 8'd0, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_DELETE_ALL, 32'd0, 8'd0, 8'd0, 1, ST_OK,        0, 0);
      add_row(ACT_DELETE_ID,  32'd5, 8'd0, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_DELETE,     32'd5, 8'd3, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_CHECK,      32'd5, 8'd3, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_CHECK_MGR,  32'd5, 8'd3, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_MGR_FINGER, 32'd5, 8'd0, 8'd0, 1, ST_NOT_FOUND, 0, 0);
      add_row(ACT_UNKNOWN_HI, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, ST_OK, 0, 0);
      add_row(ACT_UNKNOWN_LO, 32'd7, 8'd7, 8'd1, 1, ST_OK, 0, 0);
      // extremes of id, finger and manager level
      add_row(ACT_ENROLL, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, ST_OK, 0, 0);
      add_row(ACT_ENROLL, 32'h0, 8'h00, 8'h00, 1, ST_OK, 1, 0);
      add_row(ACT_ENROLL, 32'h0, 8'h01, 8'h01, 1, ST_OK, 2, 0);
      add_row(ACT_ENROLL, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      add_row(ACT_CHECK_MGR, 32'hFFFF_FFFF, 8'hFF, 8'h00);
      add_row(ACT_CHECK,     32'h0, 8'h01, 8'h00);
      add_row(ACT_MGR_FINGER, 32'h0, 8'h00, 8'h00);
      add_row(ACT_NEXT, 32'h0, 8'h00, 8'h00);
      add_row(ACT_NEXT, 32'hFFFF_FFFF, 8'h00, 8'h00);   // top finger gives 256
      add_row(ACT_COUNT, 32'h0, 8'h00, 8'h00);
      add_row(ACT_DELETE, 32'h0, 8'h00, 8'h00);
      add_row(ACT_NEXT, 32'h0, 8'h00, 8'h00);
      add_row(ACT_DELETE_ID, 32'h0, 8'h00, 8'h00);
      add_row(ACT_DELETE_ALL, 32'h0, 8'h00, 8'h00, 1, ST_OK, 0, 0);
      add_row(ACT_COUNT, 32'h0, 8'h00, 8'h00, 1, ST_OK, 0, 0);

      foreach (dir_rows[k]) send(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].e);

      // pool traffic so that ids and fingers collide often
      for (int k = 0; k < 600; k++) send(pool_req(0));

      // fill up to table full, probe, then a few full attempts
      r = '{action: ACT_DELETE_ALL, user_id: 0, finger_number: 0, manager_level: 0};
      send(r);
      for (int k = 0; k < NSLOT + 4; k++) begin
         r.action = ACT_ENROLL;
         r.user_id = id_pool[k % 8];
         r.finger_number = 8'(k / 8 + (k % 3) * 40);
         r.manager_level = 8'($urandom_range(0, 1));
         send(r);
         if (k % 40 == 0) send(pool_req(0));
      end
      for (int k = 0; k < 40; k++) send(pool_req(0));

      // wide ids mixed in
      for (int k = 0; k < 550; k++) send(pool_req(1));

      req_if.valid <= 1'b0;
      wait_cnt = 0;
      while (pending_rsp.size() != 0 && wait_cnt < 100000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (1000) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("PASS enrolled_id_slot_table_top");
      else
         $display("FAIL enrolled_id_slot_table_top");
      $finish;
   end

endmodule
